@@ rtl/psc_pkg.sv @@
package psc_pkg;

    // Width of the samples and results at the ports.
    localparam int unsigned PortSampleBits = 16;
    localparam int unsigned PortPowerBits  = 16;
    localparam int unsigned RefBits        = 16;

    typedef struct packed {
        logic signed [PortSampleBits-1:0] sample_i;
        logic signed [PortSampleBits-1:0] sample_q;
        logic                             last_in;
    } t_in_item;

    typedef struct packed {
        logic [PortPowerBits-1:0] corr_i_power;
        logic [PortPowerBits-1:0] corr_q_power;
        logic                     last_out;
    } t_out_item;

endpackage

@@ rtl/polyphase_sign_correlator.sv @@
// Polyphase sign correlator. Complex samples are dealt round-robin into
// PHASES phase classes; each class keeps a TAPS-deep window, and on every
// input transaction the window of the current class is correlated against
// the 16-bit reference pattern written through i_cfg_we/i_cfg_data (one bit
// adds the tap to the positive sum, zero to the negative sum, taps past bit
// 15 count as zero). The result transaction carries the low 16 bits of the
// squared absolute difference of the two sums per component, with all
// arithmetic wrapping at SAMPLE_BITS, plus the copied last flag. Storage is
// a chain of TAPS cells, each a PHASES-deep delay line, so the tap a of the
// current class is simply the sample seen a*PHASES transactions ago. The
// block takes one input transaction at a time: the partial sums ripple
// through the cell chain one cell per cycle, then the magnitude stage
// registers the magnitude, the square goes into the output register, and
// only then does ready rise for the next accept. A finished result may
// wait in the output register while the next input transaction is accepted
// and worked on; a stalled result that is still waiting when the next pass
// ends holds the input side off. Reset clears the windows, the pass
// state and the reference pattern; write the pattern only while the
// block is idle.
module polyphase_sign_correlator #(
    parameter int unsigned TAPS        = 16,
    parameter int unsigned PHASES      = 16,
    parameter int unsigned SAMPLE_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [15:0]          i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  psc_pkg::t_in_item    i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output psc_pkg::t_out_item   o_out_data
);

    localparam int unsigned SB    = SAMPLE_BITS;
    localparam int unsigned CNT_W = $clog2(TAPS + 1);

    // Reference pattern register.
    logic [psc_pkg::RefBits-1:0] r_ref_seq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_seq <= '0;
        end else if (i_cfg_we) begin
            r_ref_seq <= i_cfg_data;
        end
    end

    // Control: accumulate pass, magnitude stage, output register.
    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic             r_last;
    logic             r_mag_vld;
    logic             r_mag_last;
    logic [SB-1:0]    r_mag_i, r_mag_q;
    logic             r_out_vld;
    logic             w_in_acc;
    logic             w_done;
    logic             w_out_load;

    assign o_in_ready = !r_busy && !r_mag_vld;
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_done     = r_busy && (r_cnt == CNT_W'(TAPS));
    assign w_out_load = r_mag_vld && (!r_out_vld || i_out_ready);

    // Sample entry: sign-extend (or wrap) the port word to SAMPLE_BITS.
    logic [SB-1:0] w_smp_i, w_smp_q;
    assign w_smp_i = SB'(i_in_data.sample_i);
    assign w_smp_q = SB'(i_in_data.sample_q);

    // Cell chain.
    logic [SB-1:0] w_tail_i [TAPS];
    logic [SB-1:0] w_tail_q [TAPS];
    logic [SB-1:0] w_pos_i  [TAPS];
    logic [SB-1:0] w_neg_i  [TAPS];
    logic [SB-1:0] w_pos_q  [TAPS];
    logic [SB-1:0] w_neg_q  [TAPS];

    for (genvar a = 0; a < TAPS; a++) begin : g_cell
        logic          w_bit;
        logic [SB-1:0] w_din_i, w_din_q;
        logic [SB-1:0] w_pi_i, w_ni_i, w_pq_i, w_nq_i;

        if (a < psc_pkg::RefBits) begin : g_ref
            assign w_bit = r_ref_seq[a];
        end else begin : g_noref
            // Taps beyond the pattern always fall on the negative side.
            assign w_bit = 1'b0;
        end

        if (a == 0) begin : g_head
            assign w_din_i = w_smp_i;
            assign w_din_q = w_smp_q;
            assign w_pi_i  = '0;
            assign w_ni_i  = '0;
            assign w_pq_i  = '0;
            assign w_nq_i  = '0;
        end else begin : g_link
            assign w_din_i = w_tail_i[a-1];
            assign w_din_q = w_tail_q[a-1];
            assign w_pi_i  = w_pos_i[a-1];
            assign w_ni_i  = w_neg_i[a-1];
            assign w_pq_i  = w_pos_q[a-1];
            assign w_nq_i  = w_neg_q[a-1];
        end

        psc_cell #(
            .SAMPLE_BITS (SB),
            .PHASES      (PHASES)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_shift    (w_in_acc),
            .i_sample_i (w_din_i),
            .i_sample_q (w_din_q),
            .i_ref_bit  (w_bit),
            .i_pos_i    (w_pi_i),
            .i_neg_i    (w_ni_i),
            .i_pos_q    (w_pq_i),
            .i_neg_q    (w_nq_i),
            .o_tail_i   (w_tail_i[a]),
            .o_tail_q   (w_tail_q[a]),
            .o_pos_i    (w_pos_i[a]),
            .o_neg_i    (w_neg_i[a]),
            .o_pos_q    (w_pos_q[a]),
            .o_neg_q    (w_neg_q[a])
        );
    end

    // Sequencer: count the ripple, then hand off to the magnitude stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_cnt     <= '0;
            r_mag_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (w_done) begin
                r_busy <= 1'b0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
            end

            if (w_done) begin
                r_mag_vld <= 1'b1;
            end else if (w_out_load) begin
                r_mag_vld <= 1'b0;
            end

            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Magnitude: compare the sums as signed words, subtract the smaller.
    logic [SB-1:0] n_mag_i, n_mag_q;
    logic [SB-1:0] w_pi, w_ni, w_pq, w_nq;

    assign w_pi = w_pos_i[TAPS-1];
    assign w_ni = w_neg_i[TAPS-1];
    assign w_pq = w_pos_q[TAPS-1];
    assign w_nq = w_neg_q[TAPS-1];

    always_comb begin
        n_mag_i = ($signed(w_pi) > $signed(w_ni)) ? w_pi - w_ni : w_ni - w_pi;
        n_mag_q = ($signed(w_pq) > $signed(w_nq)) ? w_pq - w_nq : w_nq - w_pq;
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_last <= i_in_data.last_in;
        end
        if (w_done) begin
            r_mag_i    <= n_mag_i;
            r_mag_q    <= n_mag_q;
            r_mag_last <= r_last;
        end
    end

    // Square, wrapped to SAMPLE_BITS, then to the 16-bit result field.
    logic [SB-1:0]     w_sq_i, w_sq_q;
    psc_pkg::t_out_item r_out;

    assign w_sq_i = r_mag_i * r_mag_i;
    assign w_sq_q = r_mag_q * r_mag_q;

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out.corr_i_power <= psc_pkg::PortPowerBits'(w_sq_i);
            r_out.corr_q_power <= psc_pkg::PortPowerBits'(w_sq_q);
            r_out.last_out     <= r_mag_last;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

@@ rtl/psc_cell.sv @@
// One tap of the polyphase window: a PHASES-deep delay line of I/Q words
// plus the partial-sum stage of the correlation ripple.
module psc_cell #(
    parameter int unsigned SAMPLE_BITS = 16,
    parameter int unsigned PHASES      = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_shift,
    input  logic [SAMPLE_BITS-1:0] i_sample_i,
    input  logic [SAMPLE_BITS-1:0] i_sample_q,
    input  logic                   i_ref_bit,
    input  logic [SAMPLE_BITS-1:0] i_pos_i,
    input  logic [SAMPLE_BITS-1:0] i_neg_i,
    input  logic [SAMPLE_BITS-1:0] i_pos_q,
    input  logic [SAMPLE_BITS-1:0] i_neg_q,
    output logic [SAMPLE_BITS-1:0] o_tail_i,
    output logic [SAMPLE_BITS-1:0] o_tail_q,
    output logic [SAMPLE_BITS-1:0] o_pos_i,
    output logic [SAMPLE_BITS-1:0] o_neg_i,
    output logic [SAMPLE_BITS-1:0] o_pos_q,
    output logic [SAMPLE_BITS-1:0] o_neg_q
);

    logic [SAMPLE_BITS-1:0] r_dly_i [PHASES];
    logic [SAMPLE_BITS-1:0] r_dly_q [PHASES];
    logic [SAMPLE_BITS-1:0] r_pos_i, r_neg_i, r_pos_q, r_neg_q;
    logic [SAMPLE_BITS-1:0] n_pos_i, n_neg_i, n_pos_q, n_neg_q;

    // Entry 0 is this cell's tap; the oldest entry feeds the next cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PHASES; k++) begin
                r_dly_i[k] <= '0;
                r_dly_q[k] <= '0;
            end
        end else if (i_shift) begin
            r_dly_i[0] <= i_sample_i;
            r_dly_q[0] <= i_sample_q;
            for (int k = 1; k < PHASES; k++) begin
                r_dly_i[k] <= r_dly_i[k-1];
                r_dly_q[k] <= r_dly_q[k-1];
            end
        end
    end

    always_comb begin
        n_pos_i = i_ref_bit ? i_pos_i + r_dly_i[0] : i_pos_i;
        n_neg_i = i_ref_bit ? i_neg_i : i_neg_i + r_dly_i[0];
        n_pos_q = i_ref_bit ? i_pos_q + r_dly_q[0] : i_pos_q;
        n_neg_q = i_ref_bit ? i_neg_q : i_neg_q + r_dly_q[0];
    end

    // Sums ripple one cell per cycle; no reset needed, they settle after a pass.
    always_ff @(posedge i_clk) begin
        r_pos_i <= n_pos_i;
        r_neg_i <= n_neg_i;
        r_pos_q <= n_pos_q;
        r_neg_q <= n_neg_q;
    end

    assign o_tail_i = r_dly_i[PHASES-1];
    assign o_tail_q = r_dly_q[PHASES-1];
    assign o_pos_i  = r_pos_i;
    assign o_neg_i  = r_neg_i;
    assign o_pos_q  = r_pos_q;
    assign o_neg_q  = r_neg_q;

endmodule

@@ rtl/psc_checker.sv @@
module psc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input psc_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input psc_pkg::t_out_item o_out_data
);

    // Hold a stalled result transaction unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed or dropped while stalled");

    // Hold an offered input transaction unchanged until it is taken.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_data))
        else $error("input changed or dropped while waiting");

    // No result is pending right after reset.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // One item at a time: an accepted input closes the input side.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted while an item is in flight");

    // A new result only follows a finished pass, which blocks the input side.
    a_rise_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result appeared without a finished pass");

endmodule

bind polyphase_sign_correlator psc_checker u_psc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
